### hdl/amsgrad_pkg.sv
// Shared types and constants of the AMSGrad parameter update block.
package amsgrad_pkg;

   localparam int NUM_PARAMS = 64;
   localparam int IDX_W      = 6;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_STEP  = 2'd1;
   localparam logic [1:0] OP_DECAY = 2'd2;

   localparam logic [1:0] REG_STEP_SIZE   = 2'd0;
   localparam logic [1:0] REG_FIRST_DECAY = 2'd1;
   localparam logic [1:0] REG_SECOND_DECAY = 2'd2;
   localparam logic [1:0] REG_PEAK_DECAY  = 2'd3;

   localparam logic [63:0] EPS_Q32 = 64'd43;
   localparam logic [32:0] EPS_Q16 = 33'd1;

   // one stored entry: x, m, v, vv
   typedef struct packed {
      logic [31:0] x;
      logic [31:0] m;
      logic [63:0] v;
      logic [63:0] vv;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

### hdl/amsgrad_parameter_update.sv
// Top level of the AMSGrad parameter update block: sequencer, arithmetic, entry RAM.
// Sequence: a load or unused opcode passes read, write and output before the result is raised;
//   a step or decay item passes read, three mixes, square root, product, divider, write
//   and output.
// Requests: one at a time, taken in idle; a new one only after the output step, which
//   waits for the result register. Reset: synchronous; clears the sequencer
//   and output valid, restores the register defaults; the entry RAM is not cleared.
module amsgrad_parameter_update (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // [1:0] opcode, [7:2] param_index, [39:8] operand_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [5:0] out_index, [37:6] new_value, [39:38] zero
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_READ  = 4'd1;
   localparam logic [3:0] S_MIXM  = 4'd2;
   localparam logic [3:0] S_MIXV  = 4'd3;
   localparam logic [3:0] S_MIXP  = 4'd4;
   localparam logic [3:0] S_SQRT  = 4'd5;
   localparam logic [3:0] S_PROD  = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_WRITE = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   logic [3:0]  state_ff, state_in;
   logic [15:0] step_size_ff, first_decay_ff, second_decay_ff, peak_decay_ff;

   logic [1:0]  op_ff;
   logic [amsgrad_pkg::IDX_W-1:0] idx_ff;
   logic [31:0] opnd_ff;

   amsgrad_pkg::entry_type ent_ff, rd_ent, wr_ent;
   logic        wr_en;

   logic [6:0]  cnt_ff;
   logic [63:0] acc_ff;      // sqrt remainder / dividend, then quotient
   logic [63:0] aux_ff;      // sqrt result / division remainder
   logic [64:0] den_ff;
   logic        neg_ff;
   logic [63:0] g2_ff;

   logic        rsp_valid_ff;
   logic [amsgrad_pkg::IDX_W-1:0] rsp_idx_ff;
   logic [31:0] rsp_val_ff;
   logic        out_free;

   amsgrad_ram #(.WIDTH(amsgrad_pkg::ENTRY_W), .DEPTH(amsgrad_pkg::NUM_PARAMS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_ent),
      .rd_addr (req_tdata[7:2]),
      .rd_data (rd_ent)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_val_ff, rsp_idx_ff};
   assign wr_en      = (state_ff == S_WRITE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // ---- combinational helpers ----
   logic signed [31:0] g_s;
   logic [31:0] ag;
   assign g_s = (op_ff == amsgrad_pkg::OP_STEP) ? opnd_ff : 32'sd0;
   assign ag  = g_s[31] ? (32'd0 - g_s) : g_s;

   // products for mixes: old piece by decay and new piece by one minus decay, four pieces, then a rounding step
   logic [15:0] mix_a, mix_b, dcoef;
   logic [16:0] ecoef;
   logic [32:0] pa;
   logic [33:0] pb;
   logic [1:0]  part;
   assign part = cnt_ff[1:0];

   // signed m mix: sign-extended values split in 16-bit pieces, low 48 bits kept
   logic [63:0] ma_ext, mb_ext;
   assign ma_ext = {{32{ent_ff.m[31]}}, ent_ff.m};
   assign mb_ext = {{32{g_s[31]}}, g_s};

   always_comb begin
      mix_a = 16'd0;
      mix_b = 16'd0;
      dcoef = 16'd0;
      unique case (state_ff)
         S_MIXM: begin
            mix_a = ma_ext[16*part +: 16];
            mix_b = mb_ext[16*part +: 16];
            dcoef = first_decay_ff;
         end
         S_MIXV: begin
            mix_a = ent_ff.v[16*part +: 16];
            mix_b = g2_ff[16*part +: 16];
            dcoef = second_decay_ff;
         end
         S_MIXP: begin
            mix_a = ent_ff.vv[16*part +: 16];
            mix_b = 16'd0;
            dcoef = peak_decay_ff;
         end
         default: ;
      endcase
      ecoef = 17'h10000 - {1'b0, dcoef};
      pa = {1'b0, mix_a} * {1'b0, dcoef};
      pb = {1'b0, mix_b} * ecoef;
   end

   // partial sum shifted to position: 33+34 bits -> 35-bit contribution
   logic [34:0] psum;
   logic [95:0] acc96_add;
   assign psum = {2'b0, pa} + {1'b0, pb};

   // wide accumulator for mixes (96 bits)
   logic [95:0] macc_ff;
   assign acc96_add = macc_ff + ({61'd0, psum} << (16 * part));

   // signed m mix result
   logic [47:0] tm;
   logic [31:0] m_new;
   logic signed [47:0] qm;
   always_comb begin
      tm = macc_ff[47:0] + 48'd32768;   // 48-bit two's complement sum
      qm = $signed(tm) >>> 16;           // floor of the rounded sum
      if (qm > 48'sh7FFFFFFF)       m_new = 32'h7FFFFFFF;
      else if (qm < -48'sh80000000) m_new = 32'h80000000;
      else                          m_new = qm[31:0];
   end

   logic [63:0] u_mix;
   assign u_mix = 64'(((macc_ff + 96'd32768) >> 16));

   // sqrt step (digit-by-digit, 2 bits per cycle)
   logic [63:0] sq_bit;
   assign sq_bit = 64'd1 << (2 * (31 - cnt_ff[4:0]));

   // restoring divider step
   logic [65:0] dv_rem;
   logic [65:0] dv_sub;
   assign dv_rem = {1'b0, aux_ff, acc_ff[63]};
   assign dv_sub = dv_rem - {1'b0, den_ff};

   // step_size * |m| via one 16x32 multiply
   logic [31:0] am;
   assign am = ent_ff.m[31] ? (32'd0 - ent_ff.m) : ent_ff.m;

   // final x update
   logic signed [33:0] xr;
   logic [31:0] x_sat;
   always_comb begin
      if (neg_ff) xr = $signed({{2{ent_ff.x[31]}}, ent_ff.x}) + $signed({1'b0, acc_ff[31:0]});
      else        xr = $signed({{2{ent_ff.x[31]}}, ent_ff.x}) - $signed({1'b0, acc_ff[31:0]});
      if (acc_ff[63:32] != 32'd0)   x_sat = neg_ff ? 32'h7FFFFFFF : 32'h80000000;
      else if (xr > 34'sh7FFFFFFF)  x_sat = 32'h7FFFFFFF;
      else if (xr < -34'sh80000000) x_sat = 32'h80000000;
      else                          x_sat = xr[31:0];
   end

   // entry written back: new x for step and decay
   always_comb begin
      wr_ent = ent_ff;
      if (op_ff == amsgrad_pkg::OP_STEP || op_ff == amsgrad_pkg::OP_DECAY) begin
         wr_ent.x = x_sat;
      end
   end

   logic [63:0] s_eps;
   assign s_eps = (ent_ff.vv + amsgrad_pkg::EPS_Q32 < ent_ff.vv) ? 64'hFFFFFFFFFFFFFFFF
                                                             : ent_ff.vv + amsgrad_pkg::EPS_Q32;

   // ---- sequencer ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_tvalid && req_tready) state_in = S_READ;
         S_READ:  state_in = (op_ff == amsgrad_pkg::OP_STEP || op_ff == amsgrad_pkg::OP_DECAY)
                             ? S_MIXM : S_WRITE;
         S_MIXM:  if (cnt_ff[2:0] == 3'd4) state_in = S_MIXV;
         S_MIXV:  if (cnt_ff[2:0] == 3'd4) state_in = S_MIXP;
         S_MIXP:  if (cnt_ff[2:0] == 3'd4) state_in = S_SQRT;
         S_SQRT:  if (cnt_ff[4:0] == 5'd31) state_in = S_PROD;
         S_PROD:  state_in = S_DIV;
         S_DIV:   if (cnt_ff[5:0] == 6'd63) state_in = S_WRITE;
         S_WRITE: state_in = S_OUT;
         S_OUT:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         step_size_ff    <= 16'd105;
         first_decay_ff  <= 16'd58982;
         second_decay_ff <= 16'd65470;
         peak_decay_ff   <= 16'd64881;
         cnt_ff          <= 7'd0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               amsgrad_pkg::REG_STEP_SIZE:    step_size_ff    <= csr_wdata;
               amsgrad_pkg::REG_FIRST_DECAY:  first_decay_ff  <= csr_wdata;
               amsgrad_pkg::REG_SECOND_DECAY: second_decay_ff <= csr_wdata;
               amsgrad_pkg::REG_PEAK_DECAY:   peak_decay_ff   <= csr_wdata;
               default: ;
            endcase
         end
         priority if (state_ff == S_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready)         rsp_valid_ff <= 1'b0;
         if (state_in != state_ff) cnt_ff <= 7'd0;
         else                      cnt_ff <= cnt_ff + 7'd1;
      end
   end

   // ---- datapath ----
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            op_ff   <= req_tdata[1:0];
            idx_ff  <= req_tdata[7:2];
            opnd_ff <= req_tdata[39:8];
            macc_ff <= 96'd0;
         end
         S_READ: begin
            g2_ff   <= {32'd0, ag} * {32'd0, ag};
            if (op_ff == amsgrad_pkg::OP_LOAD) begin
               ent_ff <= '{x: opnd_ff, m: 32'd0, v: 64'd0, vv: 64'd0};
            end else begin
               ent_ff <= rd_ent;
            end
            macc_ff <= 96'd0;
         end
         S_MIXM: begin
            if (cnt_ff[2:0] == 3'd4) begin
               ent_ff.m <= m_new;
               macc_ff  <= 96'd0;
            end else begin
               macc_ff  <= acc96_add;
            end
         end
         S_MIXV: begin
            if (cnt_ff[2:0] == 3'd4) begin
               ent_ff.v <= u_mix;
               macc_ff  <= 96'd0;
            end else begin
               macc_ff  <= acc96_add;
            end
         end
         S_MIXP: begin
            if (cnt_ff[2:0] == 3'd4) begin
               ent_ff.vv <= (ent_ff.v > u_mix) ? ent_ff.v : u_mix;
               macc_ff   <= 96'd0;
               acc_ff    <= 64'd0;
               aux_ff    <= 64'd0;
            end else begin
               macc_ff   <= acc96_add;
            end
         end
         S_SQRT: begin : sq_step
            logic [63:0] n_cur, r_cur;
            logic [65:0] tr;
            n_cur = (cnt_ff[4:0] == 5'd0)
                    ? ((op_ff == amsgrad_pkg::OP_STEP) ? s_eps : ent_ff.vv) : acc_ff;
            r_cur = (cnt_ff[4:0] == 5'd0) ? 64'd0 : aux_ff;
            tr = {2'b0, n_cur} - ({2'b0, r_cur} + {2'b0, sq_bit});
            if (!tr[65]) begin
               acc_ff <= tr[63:0];
               aux_ff <= (r_cur >> 1) + sq_bit;
            end else begin
               acc_ff <= n_cur;
               aux_ff <= r_cur >> 1;
            end
         end
         S_PROD: begin
            den_ff <= (op_ff == amsgrad_pkg::OP_STEP) ? {1'b0, aux_ff}
                                                     : {1'b0, aux_ff} + amsgrad_pkg::EPS_Q16;
            neg_ff <= ent_ff.m[31];
            // dividend = |step*m| + den/2, remainder cleared
            acc_ff <= 64'({16'd0, step_size_ff} * {16'd0, am})
                      + ((op_ff == amsgrad_pkg::OP_STEP) ? (aux_ff >> 1)
                                                         : ((aux_ff + 64'd1) >> 1));
            aux_ff <= 64'd0;
         end
         S_DIV: begin
            // restoring division: aux_ff is remainder, acc_ff shifts into quotient
            if (!dv_sub[65]) begin
               aux_ff <= dv_sub[63:0];
               acc_ff <= {acc_ff[62:0], 1'b1};
            end else begin
               aux_ff <= dv_rem[63:0];
               acc_ff <= {acc_ff[62:0], 1'b0};
            end
         end
         S_WRITE: begin
            ent_ff.x <= wr_ent.x;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_idx_ff <= idx_ff;
               rsp_val_ff <= ent_ff.x;
            end
         end
         default: ;
      endcase
   end

   // ---- assertions ----
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("request taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result dropped");
   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_READ))
      else $error("accepted request not read");

endmodule

### hdl/amsgrad_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module amsgrad_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
